// ===== hdl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants shared by the shell command tokenizer files: token
// kinds, lexer modes, special byte values and the result record.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Token kinds carried on token-end results
  localparam logic [3:0] KIND_SPACE  = 4'd0;
  localparam logic [3:0] KIND_QUOTE  = 4'd1;
  localparam logic [3:0] KIND_PIPE   = 4'd2;
  localparam logic [3:0] KIND_AMP    = 4'd3;
  localparam logic [3:0] KIND_SEMI   = 4'd4;
  localparam logic [3:0] KIND_REDIR  = 4'd5;
  localparam logic [3:0] KIND_VAR    = 4'd6;
  localparam logic [3:0] KIND_ASSIGN = 4'd7;
  localparam logic [3:0] KIND_WORD   = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;

  // Lexer modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SPACE = 3'd1;
  localparam logic [2:0] MODE_QUOTE = 3'd2;
  localparam logic [2:0] MODE_GT    = 3'd3;
  localparam logic [2:0] MODE_VAR   = 3'd4;
  localparam logic [2:0] MODE_WORD  = 3'd5;

  // Special bytes
  localparam logic [7:0] CH_TICK   = 8'h27;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Most results one byte or line end can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic       is_content;
    logic [7:0] char_out;
    logic [3:0] token_kind;
    logic       quote_error;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       digits;
    logic       sep;
  } lex_state_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
    lex_state_t         next;
  } lex_out_t;

endpackage

// ===== hdl/sct_if.sv =====
// ----------------------------------------------------------------------------
// sct_cmd_if / sct_tok_if
// Valid/ready channels for command-line bytes in and token results out.
// ----------------------------------------------------------------------------
interface sct_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface sct_tok_if;
  logic       valid;
  logic       ready;
  logic       is_content;
  logic [7:0] char_out;
  logic [3:0] token_kind;
  logic       quote_error;
  logic       last_of_run;

  modport source (output valid, output is_content, output char_out, output token_kind,
                  output quote_error, output last_of_run, input ready);
  modport sink   (input valid, input is_content, input char_out, input token_kind,
                  input quote_error, input last_of_run, output ready);
endinterface

// ===== hdl/shell_command_tokenizer.sv =====
// ----------------------------------------------------------------------------
// shell_command_tokenizer
// Splits a command line, given a byte per transaction and then a line-end
// transaction, into token content bytes and token-end records.
// ----------------------------------------------------------------------------
// Path: the first result of a transaction is offered once it has passed the
//   input register and then the result buffer, which loads only when free.
// Throughput: one transaction per cycle while each gives at most one result
//   and tok.ready holds; a transaction giving more results holds the single
//   result port until the last of them has left.
// Reset: synchronous, active high; clears the lexer state and both buffers.
// ----------------------------------------------------------------------------
module shell_command_tokenizer (
  input  logic      clk,
  input  logic      rst,
  sct_cmd_if.sink   cmd,
  sct_tok_if.source tok
);
  import sct_pkg::*;

  logic               q_valid;
  logic [7:0]         q_char;
  logic               q_end;
  lex_state_t         st;
  res_t [MAX_RES-1:0] rbuf;
  logic [1:0]         rem;
  logic [1:0]         ptr;
  lex_out_t           lx;
  logic               out_fire;
  logic               buf_free;
  logic               step;
  res_t               cur;

  sct_lex u_lex (
    .st       (st),
    .char_in  (q_char),
    .line_end (q_end),
    .lx       (lx)
  );

  // Handshake: the result buffer frees as its last result leaves
  assign out_fire  = tok.valid && tok.ready;
  assign buf_free  = (rem == 2'd0) || ((rem == 2'd1) && out_fire);
  assign step      = q_valid && buf_free;
  assign cmd.ready = !q_valid || buf_free;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      st      <= '{mode: MODE_IDLE, digits: 1'b0, sep: 1'b0};
      rem     <= 2'd0;
      ptr     <= 2'd0;
    end else begin
      if (cmd.ready) q_valid <= cmd.valid;
      if (step) begin
        st  <= lx.next;
        rem <= lx.cnt;
        ptr <= 2'd0;
      end else if (out_fire) begin
        rem <= rem - 2'd1;
        ptr <= ptr + 2'd1;
      end
    end
  end

  // Payload registers: hold the pending transaction and its results
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      q_char <= cmd.char_in;
      q_end  <= cmd.line_end;
    end
    if (step) rbuf <= lx.res;
  end

  // Offer the result at the read pointer
  assign cur             = rbuf[ptr];
  assign tok.valid       = (rem != 2'd0);
  assign tok.is_content  = cur.is_content;
  assign tok.char_out    = cur.char_out;
  assign tok.token_kind  = cur.token_kind;
  assign tok.quote_error = cur.quote_error;
  assign tok.last_of_run = cur.last_of_run;

endmodule

// ===== hdl/sct_lex.sv =====
// ----------------------------------------------------------------------------
// sct_lex
// Lexer step: from the current lexer state and one byte or line end, works
// out up to three results and the next lexer state.
// ----------------------------------------------------------------------------
module sct_lex (
  input  sct_pkg::lex_state_t st,
  input  logic [7:0]          char_in,
  input  logic                line_end,
  output sct_pkg::lex_out_t   lx
);
  import sct_pkg::*;

  function automatic res_t mk(input logic content, input logic [7:0] ch,
                              input logic [3:0] kind);
    res_t r;
    r.is_content  = content;
    r.char_out    = ch;
    r.token_kind  = kind;
    r.quote_error = 1'b0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  logic is_ws, is_digit, is_delim;

  // Classify the byte
  always_comb begin
    is_ws    = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
    is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    is_delim = (char_in == CH_PIPE) || (char_in == CH_AMP) || (char_in == CH_SEMI) ||
               (char_in == CH_TICK) || (char_in == CH_DOLLAR) || (char_in == CH_LT) ||
               (char_in == CH_GT);
  end

  // Build the result list in order and the next state
  always_comb begin
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
    lex_state_t         nx;
    logic               start;
    logic               qerr;

    res   = '0;
    cnt   = 2'd0;
    nx    = st;
    start = 1'b0;
    qerr  = 1'b0;

    if (line_end) begin
      // Close the open token, then END unless a separator closed the line
      qerr = (st.mode == MODE_QUOTE);
      case (st.mode)
        MODE_QUOTE: begin
          res[cnt] = mk(1'b0, 8'd0, KIND_QUOTE); cnt = cnt + 2'd1; nx.sep = 1'b0;
        end
        MODE_SPACE: begin
          res[cnt] = mk(1'b0, 8'd0, KIND_SPACE); cnt = cnt + 2'd1; nx.sep = 1'b0;
        end
        MODE_GT: begin
          res[cnt] = mk(1'b0, 8'd0, KIND_REDIR); cnt = cnt + 2'd1; nx.sep = 1'b0;
        end
        MODE_VAR: begin
          res[cnt] = mk(1'b0, 8'd0, KIND_VAR); cnt = cnt + 2'd1; nx.sep = 1'b0;
        end
        MODE_WORD: begin
          res[cnt] = mk(1'b0, 8'd0, KIND_WORD); cnt = cnt + 2'd1; nx.sep = 1'b0;
        end
        default: begin
        end
      endcase
      if (!nx.sep) begin
        res[cnt] = mk(1'b0, 8'd0, KIND_END); cnt = cnt + 2'd1;
      end
      nx.mode   = MODE_IDLE;
      nx.digits = 1'b0;
      nx.sep    = 1'b0;
    end else begin
      // Continue or close the open token
      case (st.mode)
        MODE_QUOTE: begin
          if (char_in == CH_TICK) begin
            res[cnt] = mk(1'b0, 8'd0, KIND_QUOTE); cnt = cnt + 2'd1;
            nx.sep  = 1'b0;
            nx.mode = MODE_IDLE;
          end else begin
            res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          end
        end
        MODE_SPACE: begin
          if (!is_ws) begin
            res[cnt] = mk(1'b0, 8'd0, KIND_SPACE); cnt = cnt + 2'd1;
            nx.sep = 1'b0;
            start  = 1'b1;
          end
        end
        MODE_GT: begin
          if (char_in == CH_GT) begin
            res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
            res[cnt] = mk(1'b0, 8'd0, KIND_REDIR);    cnt = cnt + 2'd1;
            nx.sep  = 1'b0;
            nx.mode = MODE_IDLE;
          end else begin
            res[cnt] = mk(1'b0, 8'd0, KIND_REDIR); cnt = cnt + 2'd1;
            nx.sep = 1'b0;
            start  = 1'b1;
          end
        end
        MODE_VAR: begin
          if (is_delim || (char_in == CH_EQ) || is_ws) begin
            res[cnt] = mk(1'b0, 8'd0, KIND_VAR); cnt = cnt + 2'd1;
            nx.sep = 1'b0;
            start  = 1'b1;
          end else begin
            res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          end
        end
        MODE_WORD: begin
          if (char_in == CH_EQ) begin
            res[cnt] = mk(1'b0, 8'd0, KIND_ASSIGN); cnt = cnt + 2'd1;
            nx.sep    = 1'b0;
            nx.mode   = MODE_IDLE;
            nx.digits = 1'b0;
          end else if (st.digits && (char_in == CH_GT)) begin
            res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
            nx.mode   = MODE_GT;
            nx.digits = 1'b0;
          end else if (st.digits && (char_in == CH_LT)) begin
            res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
            res[cnt] = mk(1'b0, 8'd0, KIND_REDIR);    cnt = cnt + 2'd1;
            nx.sep    = 1'b0;
            nx.mode   = MODE_IDLE;
            nx.digits = 1'b0;
          end else if (is_delim || is_ws) begin
            res[cnt] = mk(1'b0, 8'd0, KIND_WORD); cnt = cnt + 2'd1;
            nx.sep = 1'b0;
            start  = 1'b1;
          end else begin
            res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
            if (!is_digit) nx.digits = 1'b0;
          end
        end
        default: begin
          start = 1'b1;
        end
      endcase

      // Open a new token with this byte
      if (start) begin
        nx.mode   = MODE_IDLE;
        nx.digits = 1'b0;
        if (is_ws) begin
          res[cnt] = mk(1'b1, CH_SPACE, KIND_SPACE); cnt = cnt + 2'd1;
          nx.mode = MODE_SPACE;
        end else if (char_in == CH_TICK) begin
          nx.mode = MODE_QUOTE;
        end else if (char_in == CH_PIPE) begin
          res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          res[cnt] = mk(1'b0, 8'd0, KIND_PIPE);     cnt = cnt + 2'd1;
          nx.sep = 1'b0;
        end else if (char_in == CH_AMP) begin
          res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          res[cnt] = mk(1'b0, 8'd0, KIND_AMP);      cnt = cnt + 2'd1;
          nx.sep = 1'b1;
        end else if (char_in == CH_SEMI) begin
          res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          res[cnt] = mk(1'b0, 8'd0, KIND_SEMI);     cnt = cnt + 2'd1;
          nx.sep = 1'b1;
        end else if (char_in == CH_LT) begin
          res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          res[cnt] = mk(1'b0, 8'd0, KIND_REDIR);    cnt = cnt + 2'd1;
          nx.sep = 1'b0;
        end else if (char_in == CH_GT) begin
          res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          nx.mode = MODE_GT;
        end else if (char_in == CH_DOLLAR) begin
          nx.mode = MODE_VAR;
        end else if (char_in == CH_EQ) begin
          res[cnt] = mk(1'b0, 8'd0, KIND_ASSIGN); cnt = cnt + 2'd1;
          nx.sep = 1'b0;
        end else begin
          res[cnt] = mk(1'b1, char_in, KIND_SPACE); cnt = cnt + 2'd1;
          nx.mode   = MODE_WORD;
          nx.digits = is_digit;
        end
      end
    end

    // Flag quote errors on every result and mark the final one
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].quote_error = qerr;
      res[i].last_of_run = (cnt != 2'd0) && (i == int'(cnt) - 1);
    end

    lx.res  = res;
    lx.cnt  = cnt;
    lx.next = nx;
  end

endmodule
